FILE: hw/rtl/sequential_list_insert_remove_core_macros.svh
// Assertion macros shared by the list core RTL.
// Included by the controller and datapath; needs nothing else.
`ifndef SEQUENTIAL_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define SEQUENTIAL_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SLIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define SLIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/slir_pkg.sv
// Shared types and codes for the sequential list core.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package slir_pkg;

    // Fixed field widths of the transaction ports
    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_REM_FRONT = 3'd3,
        ACT_REM_BACK  = 3'd4,
        ACT_REM_AT    = 3'd5,
        ACT_READ_AT   = 3'd6
    } t_action;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;        // capture a new transaction
        logic decode;       // load target index and walk pointer
        logic rd_pos;       // read memory at the target index
        logic take_result;  // capture read data as result
        logic shift;        // one shift step: read walk pointer, advance
        logic place;        // write inserted word at the target index
        logic finish;       // update count, load output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic run;          // action does work (no error, not unused code)
        logic ins;          // insert class
        logic rd;           // read-only action
        logic need_shift;   // entries must move
        logic last;         // walk pointer at final entry
        logic out_free;     // output register can take a result
    } t_sts;

endpackage

FILE: hw/rtl/slir_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module slir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/slir_dpath.sv
// Datapath of the list core: transaction registers, decode, fill count,
// list memory with shift walk, output register. Uses slir_pkg and slir_ram.
`timescale 1ns / 1ps
`include "sequential_list_insert_remove_core_macros.svh"

module slir_dpath
    import slir_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [VALUE_W-1:0]  o_removed_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = (CW > POS_W) ? CW : POS_W;

    // Transaction registers
    logic [ACTION_W-1:0]   r_action;
    logic [POS_W-1:0]      r_pos_in;
    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] r_result;

    // List control
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_wr_addr;
    logic          r_up;
    logic          r_pend;

    // Output register
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_count;

    // Decode
    logic [W-1:0]        cnt_w;
    logic [W-1:0]        pos_w;
    logic [W-1:0]        cnt_m1_w;
    logic [W-1:0]        d_eff;
    logic [W-1:0]        d_eff_p1;
    logic                d_ins;
    logic                d_rem;
    logic                d_rd;
    logic                d_err;
    logic [STATUS_W-1:0] d_status;
    logic                full;
    logic                empty;

    // Memory ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign cnt_w    = W'(r_count);
    assign pos_w    = W'(r_pos_in);
    assign cnt_m1_w = cnt_w - W'(1);
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);

    // Classify the action, resolve target index and error status
    always_comb begin
        d_ins    = 1'b0;
        d_rem    = 1'b0;
        d_rd     = 1'b0;
        d_eff    = '0;
        d_status = ST_OK;
        unique case (r_action)
            ACT_INS_FRONT: d_ins = 1'b1;
            ACT_INS_BACK: begin
                d_ins = 1'b1;
                d_eff = cnt_w;
            end
            ACT_INS_AT: begin
                d_ins = 1'b1;
                d_eff = pos_w;
            end
            ACT_REM_FRONT: d_rem = 1'b1;
            ACT_REM_BACK: begin
                d_rem = 1'b1;
                d_eff = cnt_m1_w;
            end
            ACT_REM_AT: begin
                d_rem = 1'b1;
                d_eff = pos_w;
            end
            ACT_READ_AT: begin
                d_rd  = 1'b1;
                d_eff = pos_w;
            end
            default: ;
        endcase
        if (d_ins) begin
            if (full) begin
                d_status = ST_FULL;
            end else if (d_eff > cnt_w) begin
                d_status = ST_RANGE;
            end
        end else if (d_rem || d_rd) begin
            if (empty) begin
                d_status = ST_EMPTY;
            end else if (d_eff >= cnt_w) begin
                d_status = ST_RANGE;
            end
        end
    end

    assign d_err    = (d_status != ST_OK);
    assign d_eff_p1 = d_eff + W'(1);

    // Status toward the controller
    assign o_sts.run        = !d_err && (d_ins || d_rem || d_rd);
    assign o_sts.ins        = d_ins;
    assign o_sts.rd         = d_rd;
    assign o_sts.need_shift = d_ins ? (cnt_w > d_eff) : (d_eff_p1 < cnt_w);
    assign o_sts.last       = r_up ? (r_idx == r_pos) : (r_idx == cnt_m1_w[AW-1:0]);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Capture transaction, decode target, walk the shift pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_pos_in <= i_position;
            r_value  <= DATA_WIDTH'(i_value);
            r_result <= '0;
        end
        if (i_cmd.take_result) begin
            r_result <= ram_rdata;
        end
        if (i_cmd.decode) begin
            r_pos <= d_eff[AW-1:0];
            r_up  <= d_ins;
            r_idx <= d_ins ? cnt_m1_w[AW-1:0] : d_eff_p1[AW-1:0];
        end
        if (i_cmd.shift) begin
            r_wr_addr <= r_up ? r_idx + AW'(1) : r_idx - AW'(1);
            r_idx     <= r_up ? r_idx - AW'(1) : r_idx + AW'(1);
        end
    end

    // Pending write follows each shift read in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.shift;
        end
    end

    // Memory port selection
    assign ram_re    = i_cmd.rd_pos || i_cmd.shift;
    assign ram_raddr = i_cmd.rd_pos ? r_pos : r_idx;
    assign ram_we    = r_pend || i_cmd.place;
    assign ram_waddr = r_pend ? r_wr_addr : r_pos;
    assign ram_wdata = r_pend ? ram_rdata : r_value;

    slir_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next fill count at finish
    always_comb begin
        n_count = r_count;
        if (!d_err && d_ins) begin
            n_count = r_count + CW'(1);
        end else if (!d_err && d_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
        end
    end

    // Output valid: set on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value  <= VALUE_W'(r_result);
            r_out_status <= d_status;
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_out_value;
    assign o_status        = r_out_status;
    assign o_entry_count   = r_out_count;

    `SLIR_ASSERT_IMP(a_no_write_clash, i_clk, i_rst_n, i_cmd.place, !r_pend)
    `SLIR_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `SLIR_ASSERT_NXT(a_ins_count, i_clk, i_rst_n, i_cmd.finish && d_ins && !d_err, r_count == CW'($past(r_count) + CW'(1)))

endmodule

FILE: hw/rtl/slir_ctrl.sv
// Controller of the list core: sequences decode, read, shift walk,
// placement and result hand-off. Uses slir_pkg.
`timescale 1ns / 1ps
`include "sequential_list_insert_remove_core_macros.svh"

module slir_ctrl
    import slir_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DECODE    = 8'b0000_0010,
        S_READ      = 8'b0000_0100,
        S_READ_WAIT = 8'b0000_1000,
        S_SHIFT     = 8'b0001_0000,
        S_DRAIN     = 8'b0010_0000,
        S_PLACE     = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (!i_sts.run) begin
                    n_state = S_DONE;
                end else if (i_sts.ins) begin
                    n_state = i_sts.need_shift ? S_SHIFT : S_PLACE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_pos = 1'b1;
                n_state      = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                o_cmd.take_result = 1'b1;
                n_state = (i_sts.rd || !i_sts.need_shift) ? S_DONE : S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = i_sts.ins ? S_PLACE : S_DONE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SLIR_ASSERT_NXT(a_accept_decode, i_clk, i_rst_n, accept, r_state == S_DECODE)
    `SLIR_ASSERT_IMP(a_drain_after_shift, i_clk, i_rst_n, r_state == S_DRAIN, $past(r_state) == S_SHIFT)

endmodule

FILE: hw/rtl/sequential_list_insert_remove_core.sv
// Transactions are handled one at a time: an insert walks the entries it moves, then
// places the value; a remove or read first fetches the target entry, and a remove
// then walks any entries behind it; an error or unused action code goes straight to
// the result. The shift walk moves one entry per cycle through the list memory's
// registered read port. Reset (synchronous, active low) clears the fill count and
// control state; list memory contents are not cleared and no clearing pass is run.
`timescale 1ns / 1ps

module sequential_list_insert_remove_core
    import slir_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [VALUE_W-1:0]  o_removed_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_entry_count
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    slir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // List storage and result path
    slir_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

endmodule
